// File: rtl/cafj_pkg.sv
// cafj_pkg: shared types and constants of the 8-bit cpu execute unit
// operation codes, flag layout, item structs and adjust constants
// no dependencies
`timescale 1ns / 1ps

package cafj_pkg;

    typedef enum logic [3:0] {
        MODE_INC8  = 4'd0,
        MODE_DEC8  = 4'd1,
        MODE_RLC   = 4'd2,
        MODE_RRC   = 4'd3,
        MODE_RL    = 4'd4,
        MODE_RR    = 4'd5,
        MODE_ADD16 = 4'd6,
        MODE_CPL   = 4'd7,
        MODE_DAA   = 4'd8,
        MODE_INC16 = 4'd9,
        MODE_DEC16 = 4'd10,
        MODE_JR    = 4'd11,
        MODE_JRNZ  = 4'd12,
        MODE_JRZ   = 4'd13,
        MODE_JRNC  = 4'd14,
        MODE_JRC   = 4'd15
    } mode_t;

    // bit3 z, bit2 n, bit1 h, bit0 c
    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        flags_t      flags;
    } op_item_t;

    typedef struct packed {
        logic [15:0] result;
        flags_t      flags;
        logic        jump_taken;
    } res_item_t;

    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [7:0] BCD_MAX    = 8'h99;
    localparam logic [3:0] DIGIT_MAX  = 4'd9;
    localparam logic [3:0] NIBBLE_ALL = 4'hF;

endpackage

// File: rtl/cafj_daa.sv
// cafj_daa: decimal adjust of an 8-bit accumulator after bcd add or subtract
// combinational, uses cafj_pkg
`timescale 1ns / 1ps

module cafj_daa
    import cafj_pkg::*;
(
    input  logic [7:0] value,
    input  flags_t     flags,
    output logic [7:0] adjusted,
    output flags_t     flags_new
);

    logic       hi_fix;
    logic       lo_fix;
    logic [7:0] hi_term;
    logic [7:0] lo_term;
    logic       carry;

    always_comb
    begin
        hi_fix = 1'b0;
        lo_fix = 1'b0;
        carry  = flags.c;
        if (!flags.n)
        begin
            hi_fix = flags.c || (value > BCD_MAX);
            lo_fix = flags.h || (value[3:0] > DIGIT_MAX);
            carry  = hi_fix;
        end
        else
        begin
            hi_fix = flags.c;
            lo_fix = flags.h;
        end
        hi_term = hi_fix ? DAA_HI_ADJ : 8'h00;
        lo_term = lo_fix ? DAA_LO_ADJ : 8'h00;
        if (!flags.n)
        begin
            adjusted = value + hi_term + lo_term;
        end
        else
        begin
            adjusted = value - hi_term - lo_term;
        end
        flags_new.z = (adjusted == 8'h00);
        flags_new.n = flags.n;
        flags_new.h = 1'b0;
        flags_new.c = carry;
    end

endmodule

// File: rtl/cafj_exec.sv
// cafj_exec: operation decode, arithmetic, rotates, flags and branch resolve
// combinational, uses cafj_pkg and cafj_daa
`timescale 1ns / 1ps

module cafj_exec
    import cafj_pkg::*;
(
    input  op_item_t  item,
    output res_item_t res
);

    logic [7:0]  a8;
    logic [7:0]  r8;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [15:0] target;
    logic [7:0]  daa_value;
    flags_t      daa_flags;
    flags_t      f;
    logic        go;

    assign a8 = item.operand_a[7:0];
    assign f  = item.flags;

    cafj_daa u_daa (
        .value     (a8),
        .flags     (f),
        .adjusted  (daa_value),
        .flags_new (daa_flags)
    );

    assign sum17  = {1'b0, item.operand_a} + {1'b0, item.operand_b};
    assign sum13  = {1'b0, item.operand_a[11:0]} + {1'b0, item.operand_b[11:0]};
    assign target = item.operand_a + {{8{item.operand_b[7]}}, item.operand_b[7:0]};

    always_comb
    begin
        r8             = 8'h00;
        go             = 1'b0;
        res.result     = 16'h0000;
        res.flags      = f;
        res.jump_taken = 1'b0;
        unique case (item.mode)
            MODE_INC8:
            begin
                r8         = a8 + 8'd1;
                res.result = {8'h00, r8};
                res.flags  = '{z: (r8 == 8'h00), n: 1'b0, h: (r8[3:0] == 4'h0), c: f.c};
            end
            MODE_DEC8:
            begin
                r8         = a8 - 8'd1;
                res.result = {8'h00, r8};
                res.flags  = '{z: (r8 == 8'h00), n: 1'b1, h: (r8[3:0] == NIBBLE_ALL),
                              c: f.c};
            end
            MODE_RLC:
            begin
                r8         = {a8[6:0], a8[7]};
                res.result = {8'h00, r8};
                res.flags  = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: a8[7]};
            end
            MODE_RRC:
            begin
                r8         = {a8[0], a8[7:1]};
                res.result = {8'h00, r8};
                res.flags  = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: a8[0]};
            end
            MODE_RL:
            begin
                r8         = {a8[6:0], f.c};
                res.result = {8'h00, r8};
                res.flags  = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: a8[7]};
            end
            MODE_RR:
            begin
                r8         = {f.c, a8[7:1]};
                res.result = {8'h00, r8};
                res.flags  = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: a8[0]};
            end
            MODE_ADD16:
            begin
                res.result = sum17[15:0];
                res.flags  = '{z: f.z, n: 1'b0, h: sum13[12], c: sum17[16]};
            end
            MODE_CPL:
            begin
                res.result = {8'h00, ~a8};
                res.flags  = '{z: f.z, n: 1'b1, h: 1'b1, c: f.c};
            end
            MODE_DAA:
            begin
                res.result = {8'h00, daa_value};
                res.flags  = daa_flags;
            end
            MODE_INC16:
            begin
                res.result = item.operand_a + 16'd1;
            end
            MODE_DEC16:
            begin
                res.result = item.operand_a - 16'd1;
            end
            MODE_JR, MODE_JRNZ, MODE_JRZ, MODE_JRNC, MODE_JRC:
            begin
                unique case (item.mode)
                    MODE_JRNZ: go = !f.z;
                    MODE_JRZ:  go = f.z;
                    MODE_JRNC: go = !f.c;
                    MODE_JRC:  go = f.c;
                    default:   go = 1'b1;
                endcase
                res.result     = go ? target : item.operand_a;
                res.jump_taken = go;
            end
        endcase
    end

endmodule

// File: rtl/cpu8_alu_flags_jump.sv
// cpu8_alu_flags_jump: top level of the 8-bit cpu execute unit
// input register, cafj_exec, result register; uses cafj_pkg
`timescale 1ns / 1ps

// Execute unit for an 8-bit cpu: inc/dec 8 and 16 bit, rotates, add16, cpl,
// daa and relative jumps with condition test. Every transfer in produces
// exactly one transfer out. An operation is first held in the input register
// and moves into the result register once that is free; out_valid then
// rises and the result can be taken. One operation is taken per clock while
// the output side keeps taking results. The whole operation is one pass
// through the execute logic between the two registers; a stalled output
// holds both registers, one waiting result and one queued operation.

module cpu8_alu_flags_jump
    import cafj_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  mode,
    input  logic [15:0] operand_a,
    input  logic [15:0] operand_b,
    input  logic [3:0]  flags_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] result,
    output logic [3:0]  flags_out,
    output logic        jump_taken
);

    logic      in_valid_reg;
    logic      in_valid_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    op_item_t  in_item_reg;
    op_item_t  in_item_next;
    res_item_t out_item_reg;
    res_item_t out_item_next;
    res_item_t exec_res;
    logic      in_fire;
    logic      advance;
    logic      out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;
    assign in_fire  = in_valid && in_ready;

    cafj_exec u_exec (
        .item (in_item_reg),
        .res  (exec_res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        in_item_next  = in_fire ? op_item_t'{mode: mode_t'(mode), operand_a: operand_a,
                                    operand_b: operand_b, flags: flags_t'(flags_in)}
                                : in_item_reg;
        out_item_next = advance ? exec_res : out_item_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid  = out_valid_reg;
    assign result     = out_item_reg.result;
    assign flags_out  = out_item_reg.flags;
    assign jump_taken = out_item_reg.jump_taken;

`ifndef SYNTHESIS
    // only jump operations may report a taken branch
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && exec_res.jump_taken |->
            (in_item_reg.mode == MODE_JR) || (in_item_reg.mode == MODE_JRNZ) ||
            (in_item_reg.mode == MODE_JRZ) || (in_item_reg.mode == MODE_JRNC) ||
            (in_item_reg.mode == MODE_JRC))
        else $error("jump taken on a non-jump operation");

    // 16-bit inc/dec and jumps pass flags through
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && ((in_item_reg.mode == MODE_INC16) ||
            (in_item_reg.mode == MODE_DEC16) || (in_item_reg.mode == MODE_JR) ||
            (in_item_reg.mode == MODE_JRNZ) || (in_item_reg.mode == MODE_JRZ) ||
            (in_item_reg.mode == MODE_JRNC) || (in_item_reg.mode == MODE_JRC))
        |-> exec_res.flags == in_item_reg.flags)
        else $error("flags changed by a flag-preserving operation");

    // a queued operation moves into the result register when that is free
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg && (out_item_reg == $past(exec_res)))
        else $error("operation lost between input and result register");

    // a stalled result with a queued operation blocks new transfers
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready && in_valid_reg |-> !in_ready)
        else $error("transfer accepted while both registers are full");
`endif

endmodule
